/* hdl/bsfd_pkg.sv */
// Shared types and constants for the byte-stuffed frame decoder.
// No dependencies; imported by bsfd_core and byte_stuffed_frame_decoder.
package bsfd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [1:0] CFG_END_BYTE    = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd2;

  localparam logic [7:0] START_BYTE_RST  = 8'hF7;
  localparam logic [7:0] END_BYTE_RST    = 8'h7F;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'h7D;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
  } cfg_t;

  typedef struct packed {
    logic         valid;
    result_kind_e kind;
    logic [7:0]   payload_byte;
    logic [7:0]   byte_position;
    logic [8:0]   frame_length;
    logic         overflowed;
  } res_t;

endpackage

/* hdl/bsfd_core.sv */
// Frame state and byte decode for the byte-stuffed frame decoder.
// Depends on bsfd_pkg; state advances on each accepted byte beat.
module bsfd_core #(
  parameter int unsigned FRAME_CAPACITY = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    rx_byte_i,
  input  bsfd_pkg::cfg_t cfg_i,
  output bsfd_pkg::res_t res_o
);
  import bsfd_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned PadW = (PosW > 9) ? PosW : 9;
  localparam logic [PosW-1:0] Cap = PosW'(FRAME_CAPACITY);

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [PosW-1:0] wr_pos_q, wr_pos_d;
  logic            ovf_q, ovf_d;

  logic            full;
  logic [PadW-1:0] pos_ext;
  res_t            res;

  assign full    = (wr_pos_q >= Cap);
  assign pos_ext = PadW'(wr_pos_q);

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    wr_pos_d   = wr_pos_q;
    ovf_d      = ovf_q;
    res        = '0;
    res.kind   = KIND_PAYLOAD;

    if (!in_frame_q) begin
      if (rx_byte_i == cfg_i.start_byte) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        wr_pos_d   = '0;
        ovf_d      = 1'b0;
      end
    end else if (!esc_q && rx_byte_i == cfg_i.end_byte) begin
      // end byte wins over escape when both registers match
      in_frame_d         = 1'b0;
      res.valid          = 1'b1;
      res.kind           = KIND_FRAME_END;
      res.frame_length   = pos_ext[8:0];
      res.overflowed     = ovf_q;
    end else if (!esc_q && rx_byte_i == cfg_i.escape_byte) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        res.valid         = 1'b1;
        res.payload_byte  = rx_byte_i;
        res.byte_position = pos_ext[7:0];
        wr_pos_d          = wr_pos_q + 1'b1;
      end
    end

    if (!step_i) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      wr_pos_q   <= '0;
      ovf_q      <= 1'b0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      wr_pos_q   <= wr_pos_d;
      ovf_q      <= ovf_d;
    end
  end

  assign res_o = res;

  a_esc_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> in_frame_q)
    else $error("escape pending outside a frame");

  a_pos_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pos_q <= Cap)
    else $error("write position beyond capacity");

  a_no_emit_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_PAYLOAD) |-> !full)
    else $error("payload emitted into a full frame");

  a_ovf_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && ovf_q && in_frame_q) |=> ovf_q)
    else $error("overflow flag lost inside a frame");

endmodule

/* hdl/byte_stuffed_frame_decoder.sv */
// Top level of the byte-stuffed frame decoder: config registers and result register.
// Depends on bsfd_pkg and bsfd_core.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | sink      | in_valid_i/in_ready_o  | rx_byte_i
//  out     | source    | out_valid_o/out_ready_i| result_kind_o, payload_byte_o,
//          |           |                        | byte_position_o, frame_length_o,
//          |           |                        | overflowed_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte beat per cycle unless the output stalls; its result (if any) appears in
// the result register in the cycle after the beat is taken. The result register is
// the only stall point: a new beat is taken whenever it is empty or being drained
// this cycle. Reset clears the frame state, the result valid flag and restores the
// start/end/escape bytes to 0xF7/0x7F/0x7D. Config writes are always taken.
module byte_stuffed_frame_decoder #(
  parameter int unsigned FRAME_CAPACITY = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] byte_position_o,
  output logic [8:0] frame_length_o,
  output logic       overflowed_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import bsfd_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t out_q;
  logic out_valid_q;
  logic step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= START_BYTE_RST;
      cfg_q.end_byte    <= END_BYTE_RST;
      cfg_q.escape_byte <= ESCAPE_BYTE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_BYTE:  cfg_q.start_byte  <= cfg_data_i;
        CFG_END_BYTE:    cfg_q.end_byte    <= cfg_data_i;
        CFG_ESCAPE_BYTE: cfg_q.escape_byte <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  bsfd_core #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= res.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = logic'(out_q.kind);
  assign payload_byte_o  = out_q.payload_byte;
  assign byte_position_o = out_q.byte_position;
  assign frame_length_o  = out_q.frame_length;
  assign overflowed_o    = out_q.overflowed;

  a_end_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == logic'(KIND_FRAME_END))
      |-> (payload_byte_o == 8'd0 && byte_position_o == 8'd0))
    else $error("frame end carries payload fields");

  a_payload_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == logic'(KIND_PAYLOAD))
      |-> (frame_length_o == 9'd0 && !overflowed_o))
    else $error("payload beat carries frame end fields");

  a_result_needs_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !in_valid_i) |=> !out_valid_o)
    else $error("result appeared without an input beat");

endmodule

/* tb/tb_byte_stuffed_frame_decoder.sv */
// Self-checking testbench for byte_stuffed_frame_decoder: directed table, then random frames.
// Depends on bsfd_pkg and the decoder RTL; carries its own deframing predictor.
module tb_byte_stuffed_frame_decoder;
  import bsfd_pkg::*;

  localparam int unsigned CAPACITY    = 256;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_ITEMS = 260;
  localparam int          N_DIRECTED  = 21;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   data;
    logic [7:0]   pos;
    logic [8:0]   len;
    logic         ovf;
  } frame_res_t;

  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_TYPED
  } row_chk_e;

  typedef struct packed {
    logic [7:0] b;
    row_chk_e   chk;
    frame_res_t res;
  } stim_row_t;

  localparam frame_res_t NO_RES = '0;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] rx_byte     = 8'h00;
  logic       out_ready   = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic [1:0] cfg_index   = CFG_START_BYTE;
  logic [7:0] cfg_data    = 8'h00;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       result_kind_o;
  logic [7:0] payload_byte_o;
  logic [7:0] byte_position_o;
  logic [8:0] frame_length_o;
  logic       overflowed_o;
  logic       cfg_ready_o;

  // predictor state and its copy of the registers
  logic [7:0] cfg_sof = START_BYTE_RST;
  logic [7:0] cfg_eof = END_BYTE_RST;
  logic [7:0] cfg_esc = ESCAPE_BYTE_RST;
  bit         frm_open  = 1'b0;
  bit         esc_armed = 1'b0;
  int         wr_pos    = 0;
  bit         dropped   = 1'b0;

  frame_res_t pending_results [$];
  stim_row_t  dir_tab [0:N_DIRECTED-1];
  int         errors    = 0;
  int         n_live    = 0;
  int         stall_cnt = 0;
  bit         gaps_on   = 1'b1;
  bit         hold_req  = 1'b0;

  byte_stuffed_frame_decoder #(
    .FRAME_CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .byte_position_o(byte_position_o),
    .frame_length_o (frame_length_o),
    .overflowed_o   (overflowed_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic frame_res_t payload(input logic [7:0] d, input logic [7:0] p);
    frame_res_t r;
    r      = '0;
    r.kind = KIND_PAYLOAD;
    r.data = d;
    r.pos  = p;
    return r;
  endfunction

  function automatic frame_res_t frame_end(input logic [8:0] n, input logic o);
    frame_res_t r;
    r      = '0;
    r.kind = KIND_FRAME_END;
    r.len  = n;
    r.ovf  = o;
    return r;
  endfunction

  function automatic void store_byte(input logic [7:0] b, output bit emit,
                                     output frame_res_t r);
    r    = '0;
    emit = 1'b0;
    if (wr_pos >= int'(CAPACITY)) begin
      dropped = 1'b1;
    end else begin
      emit = 1'b1;
      r    = payload(b, wr_pos[7:0]);
      wr_pos++;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, output bit emit,
                                       output frame_res_t r);
    emit = 1'b0;
    r    = '0;
    if (!frm_open) begin
      if (b == cfg_sof) begin
        frm_open  = 1'b1;
        esc_armed = 1'b0;
        wr_pos    = 0;
        dropped   = 1'b0;
      end
    end else if (esc_armed) begin
      esc_armed = 1'b0;
      store_byte(b, emit, r);
    end else if (b == cfg_eof) begin
      // end takes priority over escape when the two are equal
      frm_open = 1'b0;
      emit     = 1'b1;
      r        = frame_end(wr_pos[8:0], dropped);
    end else if (b == cfg_esc) begin
      esc_armed = 1'b1;
    end else begin
      store_byte(b, emit, r);
    end
  endfunction

  function automatic void flag(input string why, input frame_res_t want, input frame_res_t got);
    errors++;
    if (errors <= 10)
      $display({"%0t %s: exp kind=%0d data=%0h pos=%0d len=%0d ovf=%0d",
                " | got kind=%0d data=%0h pos=%0d len=%0d ovf=%0d"},
               $realtime, why, want.kind, want.data, want.pos, want.len, want.ovf,
               got.kind, got.data, got.pos, got.len, got.ovf);
  endfunction

  // one input beat; returns at the accepting edge with valid still high
  task automatic push_byte(input logic [7:0] b, input row_chk_e chk, input frame_res_t typed);
    bit         emit;
    frame_res_t r;
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    n_live++;
    deframe_byte(b, emit, r);
    case (chk)
      CHK_PRED:  if (emit) pending_results.push_back(r);
      CHK_TYPED: pending_results.push_back(typed);
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_cfg(input logic [7:0] sof, input logic [7:0] eof, input logic [7:0] esc);
    logic [1:0] idx  [3];
    logic [7:0] vals [3];
    idx[0]  = CFG_START_BYTE;
    idx[1]  = CFG_END_BYTE;
    idx[2]  = CFG_ESCAPE_BYTE;
    vals[0] = sof;
    vals[1] = eof;
    vals[2] = esc;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        CFG_START_BYTE:  cfg_sof = vals[i];
        CFG_END_BYTE:    cfg_eof = vals[i];
        CFG_ESCAPE_BYTE: cfg_esc = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // start, payload with escapes where needed, end; now and then left broken
  task automatic send_frame(input int n_data);
    logic [7:0] d;
    push_byte(cfg_sof, CHK_PRED, NO_RES);
    for (int i = 0; i < n_data; i++) begin
      d = 8'($urandom_range(255));
      if (d == cfg_eof || d == cfg_esc || $urandom_range(99) < 5)
        push_byte(cfg_esc, CHK_PRED, NO_RES);
      push_byte(d, CHK_PRED, NO_RES);
    end
    if ($urandom_range(99) < 3) push_byte(cfg_esc, CHK_PRED, NO_RES);
    if ($urandom_range(99) < 95) push_byte(cfg_eof, CHK_PRED, NO_RES);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk_i) begin
    frame_res_t got;
    frame_res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      got = '{result_kind_e'(result_kind_o), payload_byte_o, byte_position_o,
              frame_length_o, overflowed_o};
      if (pending_results.size() == 0) begin
        flag("unexpected result", NO_RES, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.pos !== want.pos ||
            got.len !== want.len || got.ovf !== want.ovf)
          flag("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("byte_stuffed_frame_decoder: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] s;
    logic [7:0] e;
    logic [7:0] x;
    // reset register values: start F7, end 7F, escape 7D
    dir_tab[0]  = '{8'h7F, CHK_NONE,  NO_RES};                 // idle: end ignored
    dir_tab[1]  = '{8'h00, CHK_NONE,  NO_RES};
    dir_tab[2]  = '{8'hF7, CHK_NONE,  NO_RES};                 // open
    dir_tab[3]  = '{8'h00, CHK_TYPED, payload(8'h00, 8'd0)};
    dir_tab[4]  = '{8'hFF, CHK_TYPED, payload(8'hFF, 8'd1)};
    dir_tab[5]  = '{8'hF7, CHK_TYPED, payload(8'hF7, 8'd2)};   // start inside frame is data
    dir_tab[6]  = '{8'h7D, CHK_NONE,  NO_RES};
    dir_tab[7]  = '{8'h7F, CHK_TYPED, payload(8'h7F, 8'd3)};   // escaped end
    dir_tab[8]  = '{8'h7D, CHK_NONE,  NO_RES};
    dir_tab[9]  = '{8'h7D, CHK_TYPED, payload(8'h7D, 8'd4)};   // escaped escape
    dir_tab[10] = '{8'h7D, CHK_NONE,  NO_RES};
    dir_tab[11] = '{8'hF7, CHK_TYPED, payload(8'hF7, 8'd5)};   // escaped start
    dir_tab[12] = '{8'h7F, CHK_TYPED, frame_end(9'd6, 1'b0)};
    dir_tab[13] = '{8'hF7, CHK_NONE,  NO_RES};
    dir_tab[14] = '{8'h7F, CHK_TYPED, frame_end(9'd0, 1'b0)};  // empty frame
    dir_tab[15] = '{8'h55, CHK_NONE,  NO_RES};
    dir_tab[16] = '{8'hF7, CHK_NONE,  NO_RES};
    dir_tab[17] = '{8'hA5, CHK_PRED,  NO_RES};
    dir_tab[18] = '{8'h7D, CHK_PRED,  NO_RES};
    dir_tab[19] = '{8'h5A, CHK_PRED,  NO_RES};
    dir_tab[20] = '{8'h7F, CHK_PRED,  NO_RES};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      push_byte(dir_tab[i].b, dir_tab[i].chk, dir_tab[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      s = 8'($urandom_range(255));
      e = 8'($urandom_range(255));
      x = 8'($urandom_range(255));
      settle();
      case (ph)
        1: load_cfg(8'h00, 8'hFF, 8'h80);
        2: load_cfg(8'hFF, 8'h00, 8'hFF);
        3: load_cfg(8'h5A, 8'h5A, 8'h5A);   // all three equal
        4: load_cfg(s, e, e);               // end and escape equal
        5: load_cfg(s, e, x);
        default: ;                          // reset values
      endcase
      gaps_on = (ph != 1);
      if (ph == 2) hold_req = 1'b1;
      n_live = 0;
      while (n_live < PHASE_ITEMS) begin
        repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), CHK_PRED, NO_RES);
        // long frames run past capacity
        if ((n_live == 0 && (ph == 1 || ph == 4)) || $urandom_range(99) < 1)
          send_frame($urandom_range(300, 260));
        else
          send_frame($urandom_range(20));
      end
    end

    settle();
    if (errors == 0 && pending_results.size() == 0)
      $display("byte_stuffed_frame_decoder: match");
    else
      $display("byte_stuffed_frame_decoder: mismatch");
    $finish;
  end

endmodule

/* files.f */
hdl/bsfd_pkg.sv
hdl/bsfd_core.sv
hdl/byte_stuffed_frame_decoder.sv
tb/tb_byte_stuffed_frame_decoder.sv
